// File: design/smpq_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the sorted min-priority queue.
// No dependencies; compiled first.
package smpq_pkg;

    // Key width of one stored entry
    localparam int KEY_W   = 32;
    // Width of the reported entry count
    localparam int COUNT_W = 5;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PLACE,
        S_POP,
        S_DONE
    } t_state;

endpackage

// File: design/smpq_in_if.sv
`timescale 1ns / 1ps
// Input channel of the sorted min-priority queue: valid/ready plus one request word.
// Depends on smpq_pkg.
interface smpq_in_if;
    import smpq_pkg::*;

    logic                     valid;
    logic                     ready;
    t_op                      opcode;
    logic signed [KEY_W-1:0]  value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface

// File: design/smpq_out_if.sv
`timescale 1ns / 1ps
// Output channel of the sorted min-priority queue: valid/ready plus one result word.
// Depends on smpq_pkg.
interface smpq_out_if;
    import smpq_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [KEY_W-1:0]    removed_value;
    t_status                    status;
    logic        [COUNT_W-1:0]  entry_count;

    modport source (output valid, output removed_value, output status, output entry_count,
                    input ready);
    modport sink   (input valid, input removed_value, input status, input entry_count,
                    output ready);
endinterface

// File: design/sorted_min_priority_queue_core.sv
`timescale 1ns / 1ps
// Sorted min-priority queue: keys kept in ascending order in a circular buffer memory.
// Depends on smpq_pkg, smpq_in_if and smpq_out_if.
//
// Usage:
//   i_in carries request words: opcode OP_INSERT stores value behind all equal or
//   smaller keys, OP_REMOVE takes out the smallest key. o_out returns one result word
//   per request: removed key (zero unless a remove succeeded), status and entry count.
//   Keys live in a DEPTH-entry memory with one write and one registered read port,
//   addressed as a ring starting at the head (smallest key). A remove only reads the
//   head and advances it. An insert walks from the tail toward the head, one entry per
//   cycle, reading the next lower entry while moving a larger one up by one slot.
// Flow: a remove passes S_POP before S_DONE; an error or an insert into an empty
//   queue goes straight to S_DONE; any other insert scans in S_SCAN from the tail
//   past the stored keys greater than the new key, through S_PLACE if it reaches the head. The single
//   memory read port sets the one-entry-per-cycle scan. One request is in flight at a
//   time; the next is accepted once the result sits in the output register.
// Reset: clears the entry count, head pointer and output valid; memory contents are
//   left as they are and are never read before written.
// Stall: a held result keeps its word stable; the next request may still be taken
//   and worked on, and waits for the output register before it completes.
module sorted_min_priority_queue_core #(
    parameter int DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    smpq_in_if.sink             i_in,
    smpq_out_if.source          o_out
);
    import smpq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW:0]   DEPTH_EXT = (AW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

    // Key storage
    logic signed [KEY_W-1:0] mem [DEPTH];

    t_state                    r_state, n_state;
    logic        [CW-1:0]      r_count;
    logic        [AW-1:0]      r_head;
    logic        [CW-1:0]      r_pos;
    logic signed [KEY_W-1:0]   r_key;
    logic signed [KEY_W-1:0]   r_rd_data;
    logic signed [KEY_W-1:0]   r_res_value;
    t_status                   r_res_status;
    logic                      r_out_valid;
    logic signed [KEY_W-1:0]   r_out_value;
    t_status                   r_out_status;
    logic        [COUNT_W-1:0] r_out_count;

    logic                      in_fire;
    logic                      out_free;
    logic                      is_full;
    logic                      is_empty;
    logic                      rd_greater;
    logic                      mem_we;
    logic        [AW-1:0]      wr_rel;
    logic signed [KEY_W-1:0]   wr_data;
    logic                      rd_en;
    logic        [AW-1:0]      rd_rel;
    logic        [AW-1:0]      wr_addr;
    logic        [AW-1:0]      rd_addr;
    logic        [AW-1:0]      head_inc;

    // Map a ring offset from the head onto a memory address
    function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] head,
                                                input logic [AW-1:0] rel);
        logic [AW:0] sum;
        sum = {1'b0, head} + {1'b0, rel};
        if (sum >= DEPTH_EXT) begin
            sum = sum - DEPTH_EXT;
        end
        return sum[AW-1:0];
    endfunction

    assign in_fire    = i_in.valid && i_in.ready;
    assign out_free   = !r_out_valid || o_out.ready;
    assign is_full    = (r_count == DEPTH_CNT);
    assign is_empty   = (r_count == '0);
    assign rd_greater = (r_rd_data > r_key);
    assign wr_addr    = ring_addr(r_head, wr_rel);
    assign rd_addr    = ring_addr(r_head, rd_rel);
    assign head_inc   = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + 1'b1;

    assign i_in.ready          = (r_state == S_IDLE);
    assign o_out.valid         = r_out_valid;
    assign o_out.removed_value = r_out_value;
    assign o_out.status        = r_out_status;
    assign o_out.entry_count   = r_out_count;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (i_in.opcode == OP_INSERT) begin
                        n_state = (is_full || is_empty) ? S_DONE : S_SCAN;
                    end else begin
                        n_state = is_empty ? S_DONE : S_POP;
                    end
                end
            end
            S_SCAN: begin
                if (!rd_greater) begin
                    n_state = S_DONE;
                end else if (r_pos == CW'(1)) begin
                    n_state = S_PLACE;
                end
            end
            S_PLACE: n_state = S_DONE;
            S_POP:   n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Memory port control
    always_comb begin
        mem_we  = 1'b0;
        wr_rel  = '0;
        wr_data = r_key;
        rd_en   = 1'b0;
        rd_rel  = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (i_in.opcode == OP_INSERT) begin
                        if (!is_full && is_empty) begin
                            mem_we  = 1'b1;
                            wr_data = i_in.value;
                        end else if (!is_full) begin
                            rd_en  = 1'b1;
                            rd_rel = AW'(r_count - 1'b1);
                        end
                    end else if (!is_empty) begin
                        rd_en = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                mem_we = 1'b1;
                wr_rel = r_pos[AW-1:0];
                if (rd_greater) begin
                    // move the larger key up one slot, fetch the next lower one
                    wr_data = r_rd_data;
                    if (r_pos > CW'(1)) begin
                        rd_en  = 1'b1;
                        rd_rel = AW'(r_pos - CW'(2));
                    end
                end
            end
            S_PLACE: begin
                mem_we = 1'b1;
            end
            S_POP, S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // Memory array
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // Control and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_head      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // drop the taken word unless a new one loads in its place
            if (o_out.valid && o_out.ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_key        <= i_in.value;
                        r_res_value  <= '0;
                        r_res_status <= ST_OK;
                        r_pos        <= r_count;
                        if (i_in.opcode == OP_INSERT) begin
                            if (is_full) begin
                                r_res_status <= ST_FULL;
                            end else if (is_empty) begin
                                r_count <= r_count + 1'b1;
                            end
                        end else if (is_empty) begin
                            r_res_status <= ST_EMPTY;
                        end
                    end
                end
                S_SCAN: begin
                    if (rd_greater) begin
                        r_pos <= r_pos - 1'b1;
                    end else begin
                        r_count <= r_count + 1'b1;
                    end
                end
                S_PLACE: begin
                    r_count <= r_count + 1'b1;
                end
                S_POP: begin
                    r_res_value <= r_rd_data;
                    r_head      <= head_inc;
                    r_count     <= r_count - 1'b1;
                end
                S_DONE: begin
                    // load the output register once it is free
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_value  <= r_res_value;
                        r_out_status <= r_res_status;
                        r_out_count  <= COUNT_W'(r_count);
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule
